@@ sv/frh_pkg.sv @@
// Shared constants, command codes and the bin divider for the equal-width histogram.
// Depends on nothing; imported by fixed_range_histogram.
`default_nettype none

package frh_pkg;

	// Command codes carried on the cmd field. The unused code acts as a plain read.
	typedef enum logic [1:0] {
		CMD_ADD        = 2'd0,
		CMD_READ       = 2'd1,
		CMD_READ_CLEAR = 2'd2
	} cmd_t;

	// Full scale of the range 0 to 100 in Q8.8.
	localparam logic [15:0] FULL_SCALE = 16'd25600;
	// Full scale with its eight fraction bits dropped: 25600 = 100 * 256.
	localparam logic [13:0] SCALE_HI = 14'd100;
	// Reset value of the bin count register.
	localparam logic [6:0] NUM_BINS_RESET = 7'd10;

	// Quotient of x by 100 for x below 12800, by seven compare and subtract steps.
	function automatic logic [6:0] div_by_scale(input logic [13:0] x);
		logic [13:0] rem;
		logic [6:0]  q;
		rem = x;
		q   = '0;
		for (int i = 6; i >= 0; i--) begin
			if (rem >= (SCALE_HI << i)) begin
				rem  = rem - (SCALE_HI << i);
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

endpackage

`default_nettype wire

@@ sv/fixed_range_histogram.sv @@
// Equal-width histogram over 0 to 100 with a dual-port count memory and forwarding.
// Depends on frh_pkg for command codes, scale constants and the bin divider.
//
// Usage:
// - The input channel (in_valid, in_ready) carries one command word: add a Q8.8
//   sample, read a bin, or read and clear a bin. The output channel (out_valid,
//   out_ready) returns exactly one result word per command, in order.
// - The user writes num_bins via num_bins_we and num_bins_wdata only while the block is
//   idle; the block does not enforce it. 0 acts as 1, above MAX_BINS as MAX_BINS.
// - A word passes through stage 1, stage 2 and the output register. Throughput is
//   one word per cycle while the receiver does not stall; the count memory is read
//   one stage ahead of its write, and a result written by the word just ahead is
//   forwarded to the next word so back-to-back hits on one bin need no wait.
// - After reset the block sweeps the count memory to zero, one entry a cycle, over all
//   MAX_BINS entries; in_ready stays low during that sweep. num_bins returns to 10.
// - When the receiver stalls, the output register holds its word and the whole
//   pipeline freezes; in_ready then follows out_ready.
`default_nettype none

module fixed_range_histogram #(
	parameter int unsigned MAX_BINS   = 64,
	parameter int unsigned COUNT_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write port.
	input  wire logic        num_bins_we,
	input  wire logic [6:0]  num_bins_wdata,
	// Command channel.
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [15:0] sample_value,
	input  wire logic [5:0]  bin_select,
	// Result channel.
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [5:0]       bin_index,
	output logic [31:0]      bin_count,
	output logic             out_of_range,
	output logic             saturated
);

	import frh_pkg::*;

	localparam int unsigned IW     = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int unsigned NB_CAP = (MAX_BINS < 127) ? MAX_BINS : 127;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Count memory.
	logic [COUNT_BITS-1:0] mem_q [MAX_BINS];

	// Configuration and clearing state.
	logic [6:0]    num_bins_q;
	logic          clr_busy_q;
	logic [IW-1:0] clr_idx_q;

	// Stage 1: accepted word with the sample already scaled by the bin count.
	logic        valid_s1;
	logic        is_add_s1;
	logic        is_clr_s1;
	logic        big_s1;
	logic [5:0]  sel_s1;
	logic [21:0] prod_s1;

	// Stage 2: memory data returns, count is modified and written back.
	logic          valid_s2;
	logic          is_add_s2;
	logic          is_clr_s2;
	logic          oor_s2;
	logic [5:0]    idx_s2;
	logic [IW-1:0] addr_s2;
	logic [COUNT_BITS-1:0] rd_data_q;
	logic                  fwd_hit_q;
	logic [COUNT_BITS-1:0] fwd_data_q;

	// Output register.
	logic        out_valid_q;
	logic [5:0]  bin_index_q;
	logic [31:0] bin_count_q;
	logic        out_of_range_q;
	logic        saturated_q;

	logic [6:0]            nb;
	logic                  en;
	logic [21:0]           prod_c;
	logic [6:0]            bin_c;
	logic                  oor_c;
	logic [5:0]            idx_c;
	logic [IW-1:0]         addr_c;
	logic [COUNT_BITS-1:0] cur_c;
	logic [COUNT_BITS-1:0] wr_data_c;
	logic [COUNT_BITS-1:0] report_c;
	logic                  wr_en_c;
	logic                  mem_we;
	logic [IW-1:0]         mem_waddr;
	logic [COUNT_BITS-1:0] mem_wdata;

	// Effective bin count, clamped to 1..MAX_BINS.
	always_comb begin
		if (num_bins_q == 7'd0) begin
			nb = 7'd1;
		end else if (num_bins_q > 7'(NB_CAP)) begin
			nb = 7'(NB_CAP);
		end else begin
			nb = num_bins_q;
		end
	end

	// The pipeline advances whenever the output register is free or being drained.
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en && !clr_busy_q;

	assign prod_c = {6'd0, sample_value} * {15'd0, nb};

	// Stage 1 logic: bin selection, range check and memory address.
	always_comb begin
		bin_c = div_by_scale(prod_s1[21:8]);
		if (is_add_s1) begin
			oor_c  = big_s1;
			idx_c  = big_s1 ? 6'd0 : bin_c[5:0];
			addr_c = IW'(bin_c);
		end else begin
			oor_c  = ({1'b0, sel_s1} >= nb);
			idx_c  = sel_s1;
			addr_c = IW'(sel_s1);
		end
	end

	// Stage 2 logic: take the forwarded count if the word ahead wrote this bin.
	always_comb begin
		cur_c     = fwd_hit_q ? fwd_data_q : rd_data_q;
		wr_data_c = '0;
		report_c  = cur_c;
		if (oor_s2) begin
			report_c = '0;
		end else if (is_add_s2) begin
			wr_data_c = (cur_c == COUNT_MAX) ? cur_c : cur_c + 1'b1;
			report_c  = wr_data_c;
		end
		wr_en_c = en && valid_s2 && !oor_s2 && (is_add_s2 || is_clr_s2);
	end

	// One write port shared by the clearing sweep and the pipeline.
	always_comb begin
		if (clr_busy_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_idx_q;
			mem_wdata = '0;
		end else begin
			mem_we    = wr_en_c;
			mem_waddr = addr_s2;
			mem_wdata = wr_data_c;
		end
	end

	// Count memory: one write and one registered read per cycle, the read gated by en.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (en) begin
			rd_data_q <= mem_q[addr_c];
		end
	end

	// Configuration register and clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bins_q <= NUM_BINS_RESET;
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else begin
			if (num_bins_we) begin
				num_bins_q <= num_bins_wdata;
			end
			if (clr_busy_q) begin
				if (clr_idx_q == IW'(MAX_BINS - 1)) begin
					clr_busy_q <= 1'b0;
				end else begin
					clr_idx_q <= clr_idx_q + 1'b1;
				end
			end
		end
	end

	// Pipeline control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			fwd_hit_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= in_valid && !clr_busy_q;
			valid_s2    <= valid_s1;
			fwd_hit_q   <= wr_en_c && valid_s1 && (addr_s2 == addr_c);
			out_valid_q <= valid_s2;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (en) begin
			is_add_s1 <= (cmd == CMD_ADD);
			is_clr_s1 <= (cmd == CMD_READ_CLEAR);
			big_s1    <= (sample_value >= FULL_SCALE);
			sel_s1    <= bin_select;
			prod_s1   <= prod_c;

			is_add_s2 <= is_add_s1;
			is_clr_s2 <= is_clr_s1;
			oor_s2    <= oor_c;
			idx_s2    <= idx_c;
			addr_s2   <= addr_c;

			fwd_data_q <= wr_data_c;

			bin_index_q    <= idx_s2;
			bin_count_q    <= 32'(report_c);
			out_of_range_q <= oor_s2;
			saturated_q    <= !oor_s2 && (report_c == COUNT_MAX);
		end
	end

	assign out_valid    = out_valid_q;
	assign bin_index    = bin_index_q;
	assign bin_count    = bin_count_q;
	assign out_of_range = out_of_range_q;
	assign saturated    = saturated_q;

	// No word may enter or travel the pipeline while the memory is being cleared.
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (!in_ready && !valid_s1 && !valid_s2))
		else $error("word in flight during memory clear");

	// An out-of-range result never carries a count or a saturation flag.
	a_oor_result_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_of_range_q) |-> (bin_count_q == 32'd0 && !saturated_q))
		else $error("out-of-range result with nonzero count");

	// A forwarding hit only rises when the pipeline wrote the memory in the previous cycle.
	a_fwd_follows_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fwd_hit_q) |-> $past(wr_en_c))
		else $error("forwarding hit without a preceding write");

	// The memory is never written for a word that was out of range.
	a_no_write_oor: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en_c && !clr_busy_q) |-> (valid_s2 && !oor_s2))
		else $error("count written for an out-of-range word");

endmodule

`default_nettype wire

@@ tb/fixed_range_histogram_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for fixed_range_histogram: a directed table, then randomized phases
// over several bin settings, each result word checked against a typed row or the local predictor.
// Depends on frh_pkg (command codes, scale and reset constants) and the fixed_range_histogram RTL.

module fixed_range_histogram_tb;
	import frh_pkg::*;

	// The fourth command code has no enum member; the block treats it as a plain read.
	localparam logic [1:0]  CMD_UNUSED      = 2'd3;
	localparam int          BIN_SLOTS       = 64;
	localparam logic [31:0] COUNT_FULL      = 32'hFFFF_FFFF;
	localparam int          PHASES          = 9;
	localparam int          WORDS_PER_PHASE = 142;
	localparam int          HOLD_CYCLES     = 48;
	localparam int          STALL_LIMIT     = 1000;
	localparam int          DIRECTED_ROWS   = 24;
	localparam int          SETTLE_CYCLES   = 4;
	localparam int          TAIL_CYCLES     = 8;

	// Bin settings per random phase; 0 and 127 exercise the clamp at both ends.
	localparam logic [6:0] BIN_SETTINGS [PHASES] = '{
		7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd7, 7'd33, 7'd3, 7'd10
	};

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] sample;
		logic [5:0]  sel;
	} word_t;

	typedef struct packed {
		logic [5:0]  idx;
		logic [31:0] count;
		logic        oor;
		logic        sat;
	} result_t;

	typedef struct packed {
		word_t   word;
		logic    typed;
		result_t res;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        num_bins_we;
	logic [6:0]  num_bins_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic [15:0] sample_value;
	logic [5:0]  bin_select;
	logic        out_valid;
	logic        out_ready;
	logic [5:0]  bin_index;
	logic [31:0] bin_count;
	logic        out_of_range;
	logic        saturated;

	// Predictor state: the bin register copy and the count of every bin.
	logic [6:0]  nb_setting;
	logic [31:0] bin_tally [BIN_SLOTS];
	result_t     pending_results [$];

	bit idle_on;
	bit stall_on;
	bit hold_req;
	int fault_count;
	int quiet_cycles;

	// Directed words, all with the reset setting of ten bins. Rows with typed results
	// are read straight off the behavior; the rest rely on the predictor.
	row_t directed_rows [DIRECTED_ROWS] = '{
		'{'{CMD_READ,       16'd0,     6'd0 }, 1'b1, '{6'd0,  32'd0, 1'b0, 1'b0}},
		'{'{CMD_READ,       16'd0,     6'd9 }, 1'b1, '{6'd9,  32'd0, 1'b0, 1'b0}},
		'{'{CMD_READ,       16'd65535, 6'd10}, 1'b1, '{6'd10, 32'd0, 1'b1, 1'b0}},
		'{'{CMD_READ_CLEAR, 16'd0,     6'd63}, 1'b1, '{6'd63, 32'd0, 1'b1, 1'b0}},
		'{'{CMD_ADD,        16'd0,     6'd0 }, 1'b1, '{6'd0,  32'd1, 1'b0, 1'b0}},
		'{'{CMD_ADD,        16'd25599, 6'd0 }, 1'b1, '{6'd9,  32'd1, 1'b0, 1'b0}},
		'{'{CMD_ADD,        16'd25600, 6'd0 }, 1'b1, '{6'd0,  32'd0, 1'b1, 1'b0}},
		'{'{CMD_ADD,        16'd65535, 6'd63}, 1'b1, '{6'd0,  32'd0, 1'b1, 1'b0}},
		'{'{CMD_ADD,        16'd2560,  6'd0 }, 1'b1, '{6'd1,  32'd1, 1'b0, 1'b0}},
		'{'{CMD_ADD,        16'd2559,  6'd0 }, 1'b1, '{6'd0,  32'd2, 1'b0, 1'b0}},
		'{'{CMD_READ_CLEAR, 16'd0,     6'd0 }, 1'b1, '{6'd0,  32'd2, 1'b0, 1'b0}},
		'{'{CMD_READ,       16'd0,     6'd0 }, 1'b1, '{6'd0,  32'd0, 1'b0, 1'b0}},
		'{'{CMD_UNUSED,     16'd0,     6'd9 }, 1'b1, '{6'd9,  32'd1, 1'b0, 1'b0}},
		'{'{CMD_UNUSED,     16'd0,     6'd9 }, 1'b1, '{6'd9,  32'd1, 1'b0, 1'b0}},
		'{'{CMD_ADD,        16'd12800, 6'd0 }, 1'b1, '{6'd5,  32'd1, 1'b0, 1'b0}},
		'{'{CMD_ADD,        16'd12800, 6'd0 }, 1'b1, '{6'd5,  32'd2, 1'b0, 1'b0}},
		'{'{CMD_READ_CLEAR, 16'd0,     6'd5 }, 1'b1, '{6'd5,  32'd2, 1'b0, 1'b0}},
		'{'{CMD_ADD,        16'd12800, 6'd0 }, 1'b1, '{6'd5,  32'd1, 1'b0, 1'b0}},
		'{'{CMD_ADD,        16'd12801, 6'd17}, 1'b0, '0},
		'{'{CMD_ADD,        16'd30000, 6'd0 }, 1'b0, '0},
		'{'{CMD_ADD,        16'd7680,  6'd42}, 1'b0, '0},
		'{'{CMD_UNUSED,     16'd5,     6'd63}, 1'b0, '0},
		'{'{CMD_READ_CLEAR, 16'd0,     6'd9 }, 1'b0, '0},
		'{'{CMD_ADD,        16'd25599, 6'd0 }, 1'b0, '0}
	};

	fixed_range_histogram uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.num_bins_we    (num_bins_we),
		.num_bins_wdata (num_bins_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.sample_value   (sample_value),
		.bin_select     (bin_select),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.bin_index      (bin_index),
		.bin_count      (bin_count),
		.out_of_range   (out_of_range),
		.saturated      (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Bin setting as the block uses it: zero acts as one, anything above 64 as 64.
	function automatic int active_bins();
		if (nb_setting == 7'd0)
			return 1;
		if (int'(nb_setting) > BIN_SLOTS)
			return BIN_SLOTS;
		return int'(nb_setting);
	endfunction

	// Applies one command word to the local bin counts and returns the expected result.
	function automatic result_t tally_word(input word_t w);
		result_t r;
		int      nb;
		int      b;
		nb = active_bins();
		r  = '0;
		if (w.op == CMD_ADD) begin
			if (w.sample >= FULL_SCALE) begin
				r.oor = 1'b1;
			end else begin
				b = (int'(w.sample) * nb) / int'(FULL_SCALE);
				if (bin_tally[b] != COUNT_FULL)
					bin_tally[b] = bin_tally[b] + 32'd1;
				r.idx   = 6'(b);
				r.count = bin_tally[b];
				r.sat   = (bin_tally[b] == COUNT_FULL);
			end
		end else if (int'(w.sel) >= nb) begin
			r.idx = w.sel;
			r.oor = 1'b1;
		end else begin
			r.idx   = w.sel;
			r.count = bin_tally[w.sel];
			r.sat   = (bin_tally[w.sel] == COUNT_FULL);
			if (w.op == CMD_READ_CLEAR)
				bin_tally[w.sel] = '0;
		end
		return r;
	endfunction

	// Offers one word, holds it until accepted, then records what it should produce.
	// A typed result stands in for the prediction, but the predictor still advances.
	task automatic send_word(input word_t w, input logic typed, input result_t res);
		result_t predicted;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= w.op;
		sample_value <= w.sample;
		bin_select   <= w.sel;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = tally_word(w);
		pending_results.push_back(typed ? res : predicted);
	endtask

	// Waits until every expected word has come back.
	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Receiver: short random stalls, plus one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (stall_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Compare each result word against the oldest expectation.
	always @(posedge clk) begin
		result_t seen;
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			seen = '{bin_index, bin_count, out_of_range, saturated};
			if (pending_results.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("%0t: unexpected word idx/count/oor/sat %0d/%0d/%0b/%0b",
						$realtime, seen.idx, seen.count, seen.oor, seen.sat);
			end else begin
				want = pending_results.pop_front();
				if (seen !== want) begin
					fault_count++;
					if (fault_count <= 10)
						$display("%0t: expected %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
							$realtime, want.idx, want.count, want.oor, want.sat,
							seen.idx, seen.count, seen.oor, seen.sat);
				end
			end
		end
	end

	// Watchdog: too long without any word moving on either channel ends the run.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Main sequence: reset, directed table, then one random phase per bin setting.
	initial begin
		word_t       w;
		int          nb;
		int          k;
		int          b;
		int          boundary;
		logic [15:0] last_sample;
		arst_n         = 1'b0;
		num_bins_we    = 1'b0;
		num_bins_wdata = NUM_BINS_RESET;
		in_valid       = 1'b0;
		cmd            = CMD_ADD;
		sample_value   = '0;
		bin_select     = '0;
		idle_on        = 1'b1;
		stall_on       = 1'b1;
		hold_req       = 1'b0;
		fault_count    = 0;
		quiet_cycles   = 0;
		last_sample    = '0;
		nb_setting     = NUM_BINS_RESET;
		foreach (bin_tally[i])
			bin_tally[i] = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].res);

		for (int ph = 0; ph < PHASES; ph++) begin
			// Change the bin setting only with the pipeline empty.
			in_valid <= 1'b0;
			drain();
			repeat (SETTLE_CYCLES) @(posedge clk);
			num_bins_we    <= 1'b1;
			num_bins_wdata <= BIN_SETTINGS[ph];
			@(posedge clk);
			num_bins_we <= 1'b0;
			nb_setting = BIN_SETTINGS[ph];

			// The final phase runs with no idling on either side.
			idle_on  = (ph != PHASES - 1);
			stall_on = (ph != PHASES - 1);
			if (ph == 1)
				hold_req = 1'b1;

			repeat (WORDS_PER_PHASE) begin
				nb       = active_bins();
				k        = $urandom_range(0, 99);
				w.sample = 16'($urandom_range(0, 65535));
				w.sel    = 6'($urandom_range(0, 63));
				if (k < 65) begin
					w.op = CMD_ADD;
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5: w.sample = 16'($urandom_range(0, 25599));
						6: w.sample = 16'($urandom_range(25600, 65535));
						7: begin
							// First sample of a bin, or the last one of the bin below.
							b        = $urandom_range(0, nb - 1);
							boundary = (b * 25600 + nb - 1) / nb;
							if (boundary > 0 && $urandom_range(0, 1) == 1)
								boundary = boundary - 1;
							w.sample = 16'(boundary);
						end
						8: w.sample = last_sample;
						default: w.sample = ($urandom_range(0, 1) == 1) ? 16'd25599 : 16'd0;
					endcase
					last_sample = w.sample;
				end else begin
					w.op = (k < 80) ? CMD_READ : (k < 93) ? CMD_READ_CLEAR : CMD_UNUSED;
					if ($urandom_range(0, 4) != 0)
						w.sel = 6'($urandom_range(0, nb - 1));
				end
				send_word(w, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
